[rtl/core/lpms_pkg.sv]
// Shared types, constants and helpers for the long-press mode selector.
// Depends on nothing; used by lpms_button and long_press_mode_selector.

package lpms_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned LEVEL_W = 8;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd5000;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_HALF = 8'd128;
    localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'd0;

    typedef enum logic [1:0] {
        MODE_STD = 2'd0,
        MODE_ECO = 2'd1,
        MODE_MNT = 2'd2
    } mode_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] red;
    } colour_t;

    typedef struct packed {
        logic fire;
        logic locked;
    } btn_status_t;

    // Indicator colour for a mode; the unused code shows as standard.
    function automatic colour_t mode_colour(input logic [1:0] mode);
        colour_t c;
        case (mode)
            MODE_ECO:
            begin
                c.red   = LEVEL_OFF;
                c.green = LEVEL_OFF;
                c.blue  = LEVEL_FULL;
            end
            MODE_MNT:
            begin
                c.red   = LEVEL_FULL;
                c.green = LEVEL_HALF;
                c.blue  = LEVEL_OFF;
            end
            default:
            begin
                c.red   = LEVEL_OFF;
                c.green = LEVEL_FULL;
                c.blue  = LEVEL_OFF;
            end
        endcase
        return c;
    endfunction

endpackage

[rtl/core/lpms_button.sv]
// Long-press tracker for one button, pressed while down is high: press flag, lock flag and press time.
// Depends on lpms_pkg.

module lpms_button
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               down,
    input  logic [lpms_pkg::TIME_W-1:0]        now_ms,
    input  logic [lpms_pkg::HOLD_W-1:0]        hold_ms,
    output lpms_pkg::btn_status_t              status
);

    logic                          pressed_reg;
    logic                          pressed_next;
    logic                          locked_reg;
    logic                          locked_next;
    logic [lpms_pkg::TIME_W-1:0]   stamp_reg;
    logic [lpms_pkg::TIME_W-1:0]   stamp_next;
    logic                          new_press;
    logic                          locked_mid;
    logic [lpms_pkg::TIME_W-1:0]   elapsed;
    logic                          fire;

    always_comb
    begin
        new_press    = down && !pressed_reg;
        pressed_next = down;
        stamp_next   = new_press ? now_ms : stamp_reg;
        locked_mid   = new_press ? 1'b0 : locked_reg;
        elapsed      = now_ms - stamp_next;
        fire         = down && !locked_mid &&
                       (elapsed >= {{(lpms_pkg::TIME_W-lpms_pkg::HOLD_W){1'b0}}, hold_ms});
        locked_next  = locked_mid || fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            locked_reg  <= 1'b0;
            stamp_reg   <= '0;
        end
        else if (en)
        begin
            pressed_reg <= pressed_next;
            locked_reg  <= locked_next;
            stamp_reg   <= stamp_next;
        end
    end

    assign status.fire   = fire;
    assign status.locked = locked_reg;

endmodule

[rtl/core/long_press_mode_selector.sv]
// Top level of the long-press mode selector: stream ports, mode logic and result register.
// Depends on lpms_pkg and lpms_button.

// Each request carries one sample of two active-low buttons and a millisecond
// timestamp, and yields exactly one result with the mode, its LED colour and a
// change flag. A request passes through the input register, then the result
// register, and one request is taken every cycle while the output is not stalled,
// since the button and mode state is updated in the same cycle that loads the result
// register. hold_ms may be written only while no request is in flight.

module long_press_mode_selector
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // hold_ms
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // now_ms[31:0], button1_level[32], button2_level[33]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // mode[1:0], led_red[9:2], led_green[17:10],
                                        // led_blue[25:18], mode_changed[26]
);

    logic [lpms_pkg::HOLD_W-1:0]  hold_ms_reg;
    logic                         in_valid_reg;
    logic [33:0]                  in_data_reg;
    logic                         out_valid_reg;
    logic [31:0]                  out_data_reg;
    logic [31:0]                  out_data_next;
    logic [1:0]                   active_mode_reg;
    logic [1:0]                   active_mode_next;
    logic                         return_mode_reg;
    logic                         return_mode_next;
    logic                         advance;
    logic [1:0]                   mode_mid;
    logic                         changed;
    lpms_pkg::btn_status_t        btn1;
    lpms_pkg::btn_status_t        btn2;
    lpms_pkg::colour_t            colour;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    lpms_button u_btn1
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .down    (!in_data_reg[32]),
        .now_ms  (in_data_reg[31:0]),
        .hold_ms (hold_ms_reg),
        .status  (btn1)
    );

    lpms_button u_btn2
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .down    (!in_data_reg[33]),
        .now_ms  (in_data_reg[31:0]),
        .hold_ms (hold_ms_reg),
        .status  (btn2)
    );

    // Button 1 acts first, so button 2 sees the mode that button 1 may have set.
    always_comb
    begin
        mode_mid         = active_mode_reg;
        return_mode_next = return_mode_reg;
        changed          = 1'b0;
        if (btn1.fire)
        begin
            case (active_mode_reg)
                lpms_pkg::MODE_STD:
                begin
                    mode_mid = lpms_pkg::MODE_ECO;
                    changed  = 1'b1;
                end
                lpms_pkg::MODE_ECO:
                begin
                    mode_mid = lpms_pkg::MODE_STD;
                    changed  = 1'b1;
                end
                default:
                begin
                    mode_mid = active_mode_reg;
                end
            endcase
        end
        active_mode_next = mode_mid;
        if (btn2.fire)
        begin
            changed = 1'b1;
            if (mode_mid == lpms_pkg::MODE_MNT)
            begin
                active_mode_next = return_mode_reg ? lpms_pkg::MODE_ECO : lpms_pkg::MODE_STD;
            end
            else
            begin
                return_mode_next = (mode_mid == lpms_pkg::MODE_ECO);
                active_mode_next = lpms_pkg::MODE_MNT;
            end
        end
        colour        = lpms_pkg::mode_colour(active_mode_next);
        out_data_next = {5'd0, changed, colour.blue, colour.green, colour.red, active_mode_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ms_reg     <= lpms_pkg::HOLD_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            active_mode_reg <= lpms_pkg::MODE_STD;
            return_mode_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                hold_ms_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                active_mode_reg <= active_mode_next;
                return_mode_reg <= return_mode_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata[33:0];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_mode_holds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !changed |=> $stable(active_mode_reg))
        else $error("mode moved without a long press");

    a_lock_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
        advance && btn1.fire |=> btn1.locked)
        else $error("button 1 not locked after firing");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed request produced no result");

endmodule

[tb/tb_long_press_mode_selector.sv]
// Self-checking testbench for long_press_mode_selector: directed button sequences, then
// random press and release traffic under several hold times, with random idling on both sides in most runs.
// Depends on lpms_pkg and the selector RTL; it predicts every result itself.

module tb_long_press_mode_selector;

    typedef struct {
        lpms_pkg::mode_t mode;
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
        logic            changed;
    } mode_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    mode_result_t expected_results[$];
    int unsigned  mismatches = 0;
    int unsigned  results_seen = 0;
    int unsigned  ready_stall = 0;
    bit           gaps_on = 1'b0;

    logic [15:0]     hold_time;
    logic            btn_pressed[2];
    logic            btn_locked[2];
    logic [31:0]     btn_stamp[2];
    lpms_pkg::mode_t cur_mode;
    logic            back_to_eco;

    long_press_mode_selector u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    // Updates one button's tracker and tells whether it fires on this sample.
    function automatic logic button_fires(input int idx, input logic down,
                                          input logic [31:0] now);
        logic fires;
        fires = 1'b0;
        if (down && !btn_pressed[idx])
        begin
            btn_stamp[idx]   = now;
            btn_locked[idx]  = 1'b0;
            btn_pressed[idx] = 1'b1;
        end
        else if (!down && btn_pressed[idx])
        begin
            btn_pressed[idx] = 1'b0;
        end
        if (btn_pressed[idx] && down && !btn_locked[idx] &&
            (now - btn_stamp[idx]) >= {16'd0, hold_time})
        begin
            btn_locked[idx] = 1'b1;
            fires = 1'b1;
        end
        return fires;
    endfunction

    function automatic void predict_mode_result(input logic [31:0] now, input logic lvl1,
                                                input logic lvl2);
        mode_result_t r;
        r.changed = 1'b0;
        if (button_fires(0, !lvl1, now))
        begin
            if (cur_mode == lpms_pkg::MODE_STD)
            begin
                cur_mode  = lpms_pkg::MODE_ECO;
                r.changed = 1'b1;
            end
            else if (cur_mode == lpms_pkg::MODE_ECO)
            begin
                cur_mode  = lpms_pkg::MODE_STD;
                r.changed = 1'b1;
            end
        end
        if (button_fires(1, !lvl2, now))
        begin
            if (cur_mode == lpms_pkg::MODE_MNT)
            begin
                cur_mode = back_to_eco ? lpms_pkg::MODE_ECO : lpms_pkg::MODE_STD;
            end
            else
            begin
                back_to_eco = (cur_mode == lpms_pkg::MODE_ECO);
                cur_mode    = lpms_pkg::MODE_MNT;
            end
            r.changed = 1'b1;
        end
        r.mode = cur_mode;
        case (cur_mode)
            lpms_pkg::MODE_ECO:
                {r.red, r.green, r.blue} =
                    {lpms_pkg::LEVEL_OFF, lpms_pkg::LEVEL_OFF, lpms_pkg::LEVEL_FULL};
            lpms_pkg::MODE_MNT:
                {r.red, r.green, r.blue} =
                    {lpms_pkg::LEVEL_FULL, lpms_pkg::LEVEL_HALF, lpms_pkg::LEVEL_OFF};
            default:
                {r.red, r.green, r.blue} =
                    {lpms_pkg::LEVEL_OFF, lpms_pkg::LEVEL_FULL, lpms_pkg::LEVEL_OFF};
        endcase
        expected_results.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 50)
        begin
            $display("result %0d: %s mismatch, got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
        end
    endtask

    task automatic send_sample(input logic [31:0] now, input logic lvl1, input logic lvl2);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, lvl2, lvl1, now};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_mode_result(now, lvl1, lvl2);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_hold(input logic [15:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        hold_time = value;
    endtask

    always @(posedge clk)
    begin : result_monitor
        mode_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", m_axis_tdata, 32'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[1:0] !== want.mode)
                    report_mismatch("mode", 32'(m_axis_tdata[1:0]), 32'(want.mode));
                if (m_axis_tdata[9:2] !== want.red)
                    report_mismatch("led_red", 32'(m_axis_tdata[9:2]), 32'(want.red));
                if (m_axis_tdata[17:10] !== want.green)
                    report_mismatch("led_green", 32'(m_axis_tdata[17:10]),
                                    32'(want.green));
                if (m_axis_tdata[25:18] !== want.blue)
                    report_mismatch("led_blue", 32'(m_axis_tdata[25:18]), 32'(want.blue));
                if (m_axis_tdata[26] !== want.changed)
                    report_mismatch("mode_changed", 32'(m_axis_tdata[26]),
                                    32'(want.changed));
            end
            ready_stall = gaps_on ? $urandom_range(0, 16) : 0;
        end
        if (ready_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            ready_stall--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // The hold time left at its reset value: one short of it, then exactly it.
    task automatic test_reset_hold();
        send_sample(32'd0, 1'b1, 1'b1);
        send_sample(32'd100, 1'b0, 1'b1);
        send_sample(32'd5099, 1'b0, 1'b1);
        send_sample(32'd5100, 1'b0, 1'b1);
        send_sample(32'd5200, 1'b1, 1'b1);
    endtask

    // With no hold time a press fires at once; both buttons together act in order.
    task automatic test_zero_hold();
        set_hold(16'd0);
        send_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_sample(32'd0, 1'b1, 1'b1);
        send_sample(32'd1, 1'b1, 1'b0);
        send_sample(32'd2, 1'b1, 1'b1);
        send_sample(32'd3, 1'b0, 1'b0);
        send_sample(32'd4, 1'b1, 1'b1);
        send_sample(32'd5, 1'b0, 1'b0);
        send_sample(32'd6, 1'b1, 1'b1);
    endtask

    // The longest hold across the timestamp wrap; a locked button must not fire again
    // when the elapsed time wraps round to a small value.
    task automatic test_max_hold();
        logic [31:0] t;
        t = 32'hFFFF_FFF0;
        set_hold(16'hFFFF);
        send_sample(t, 1'b0, 1'b1);
        send_sample(t + 32'd65534, 1'b0, 1'b1);
        send_sample(t + 32'd65535, 1'b0, 1'b1);
        send_sample(t + 32'd5, 1'b0, 1'b1);
        send_sample(t + 32'd70000, 1'b1, 1'b1);
        send_sample(32'd7, 1'b1, 1'b0);
        send_sample(32'd65541, 1'b1, 1'b0);
        send_sample(32'd65542, 1'b1, 1'b0);
        send_sample(32'd65543, 1'b1, 1'b1);
    endtask

    // Presses and releases of random length on a steadily advancing clock, with the odd
    // sample that jumps to a random timestamp and random levels.
    task automatic test_random_traffic(input logic [15:0] hold, input int count,
                                       input bit gaps, input int pause_at);
        logic [31:0] now;
        logic        lvl1;
        logic        lvl2;
        int          left1;
        int          left2;
        set_hold(hold);
        gaps_on = gaps;
        now   = $urandom();
        lvl1  = 1'b1;
        lvl2  = 1'b1;
        left1 = 1;
        left2 = 1;
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                drain_results();
            left1--;
            if (left1 == 0)
            begin
                lvl1  = ~lvl1;
                left1 = $urandom_range(1, 8);
            end
            left2--;
            if (left2 == 0)
            begin
                lvl2  = ~lvl2;
                left2 = $urandom_range(1, 8);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_sample($urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                now = now + $urandom_range(0, hold / 2 + 2);
                send_sample(now, lvl1, lvl2);
            end
        end
    endtask

    initial
    begin
        hold_time   = lpms_pkg::HOLD_RESET;
        cur_mode    = lpms_pkg::MODE_STD;
        back_to_eco = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            btn_pressed[i] = 1'b0;
            btn_locked[i]  = 1'b0;
            btn_stamp[i]   = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gaps_on = 1'b1;
        test_reset_hold();
        test_zero_hold();
        test_max_hold();
        test_random_traffic(16'd0, 100, 1'b1, -1);
        test_random_traffic(16'd1, 100, 1'b0, -1);
        test_random_traffic(16'hFFFF, 150, 1'b1, 75);
        repeat (3) test_random_traffic(16'($urandom_range(0, 65535)), 120, 1'b1, -1);
        test_random_traffic(lpms_pkg::HOLD_RESET, 90, 1'b1, -1);
        drain_results();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
